### hw/rtl/usbcfg_pkg.sv
// usbcfg_pkg: shared constants and types for the USB configuration descriptor parser.
// No dependencies; imported by usb_config_descriptor_parser.
`default_nettype none

package usbcfg_pkg;

    // Descriptor types
    localparam logic [7:0] DT_CONFIGURATION = 8'h02;
    localparam logic [7:0] DT_INTERFACE     = 8'h04;
    localparam logic [7:0] DT_ENDPOINT      = 8'h05;

    // HID boot mouse interface codes
    localparam logic [7:0] HID_CLASS          = 8'h03;
    localparam logic [7:0] HID_BOOT_SUBCLASS  = 8'h01;
    localparam logic [7:0] HID_MOUSE_PROTOCOL = 8'h02;

    // Endpoint attribute fields
    localparam logic [7:0] EP_DIR_IN         = 8'h80;
    localparam logic [7:0] EP_TYPE_MASK      = 8'h03;
    localparam logic [7:0] EP_TYPE_INTERRUPT = 8'h03;
    localparam logic [7:0] EP_NUM_MASK       = 8'h0F;

    // Minimum descriptor lengths
    localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
    localparam logic [7:0] MIN_CONFIG_LEN = 8'd9;
    localparam logic [7:0] MIN_IFACE_LEN  = 8'd9;
    localparam logic [7:0] MIN_EP_LEN     = 8'd7;

    // Byte positions inside a descriptor
    localparam logic [7:0] POS_LENGTH     = 8'd0;
    localparam logic [7:0] POS_TYPE       = 8'd1;
    localparam logic [7:0] POS_CFG_VALUE  = 8'd5;
    localparam logic [7:0] POS_IF_NUMBER  = 8'd2;
    localparam logic [7:0] POS_IF_CLASS   = 8'd5;
    localparam logic [7:0] POS_IF_SUB     = 8'd6;
    localparam logic [7:0] POS_IF_PROTO   = 8'd7;
    localparam logic [7:0] POS_EP_ADDR    = 8'd2;
    localparam logic [7:0] POS_EP_ATTR    = 8'd3;
    localparam logic [7:0] POS_EP_MPS_LO  = 8'd4;
    localparam logic [7:0] POS_EP_MPS_HI  = 8'd5;
    localparam logic [7:0] POS_EP_INTERVL = 8'd6;

    localparam logic [15:0] SET_LENGTH_RESET = 16'd9;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LEN_SHORT   = 3'd1,
        ST_OVERRUN     = 3'd2,
        ST_SHORT_CFG   = 3'd3,
        ST_SHORT_IFACE = 3'd4,
        ST_SHORT_EP    = 3'd5
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/usb_config_descriptor_parser.sv
// usb_config_descriptor_parser: byte-serial walker of a USB configuration descriptor set.
// Depends on usbcfg_pkg (descriptor codes, status type).
`default_nettype none

// Takes one descriptor byte per beat and walks the sub-descriptor chain by
// the length bytes. Each byte goes into an input register; one short layer of
// logic checks lengths and captures fields, and any result lands in an output
// register. Throughput is one byte per clock while in_stall is low. A beat
// flagged first_byte clears all parse state and starts a new set. At most one
// result beat comes per set: at the first length error, or when the byte
// count reaches the set length. Bytes after that are dropped until the next
// first_byte. The input register keeps taking bytes while a result beat waits
// downstream; only a byte that would produce a second result holds in the
// input register, and then in_stall rises. The set length must be written
// through cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
module usb_config_descriptor_parser
    import usbcfg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // byte input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       parse_status,
    output logic [7:0]       config_value,
    output logic [7:0]       iface_number,
    output logic [7:0]       iface_class,
    output logic [7:0]       iface_subclass,
    output logic [7:0]       iface_protocol,
    output logic             mouse_found,
    output logic [3:0]       mouse_endpoint,
    output logic [15:0]      endpoint_max_packet,
    output logic [7:0]       endpoint_interval
);

    logic [15:0] set_len_reg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;

    // parse state
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic        halted_reg, halted_next;
    logic        mouse_reg, mouse_next;
    logic [7:0]  cfg_val_reg, cfg_val_next;
    logic [7:0]  if_num_reg, if_num_next;
    logic [7:0]  if_class_reg, if_class_next;
    logic [7:0]  if_sub_reg, if_sub_next;
    logic [7:0]  if_proto_reg, if_proto_next;
    // endpoint scratch: number, IN flag, interrupt flag, max packet
    logic [3:0]  ep_num_reg, ep_num_next;
    logic        ep_in_reg, ep_in_next;
    logic        ep_int_reg, ep_int_next;
    logic [15:0] ep_mps_reg, ep_mps_next;
    // recorded interrupt IN endpoint
    logic [3:0]  rec_num_reg, rec_num_next;
    logic [15:0] rec_mps_reg, rec_mps_next;
    logic [7:0]  rec_ivl_reg, rec_ivl_next;

    logic        result_now;
    status_t     status_now;
    logic        s1_go;
    logic        in_fire;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [7:0]  out_cfg_reg, out_ifn_reg, out_ifc_reg, out_ifs_reg, out_ifp_reg;
    logic        out_mouse_reg;
    logic [3:0]  out_epn_reg;
    logic [15:0] out_mps_reg;
    logic [7:0]  out_ivl_reg;

    // ---------------------------------------------------------------
    // Byte decode: all the parse work for the byte in the input register
    // ---------------------------------------------------------------
    always_comb
    begin
        logic        clr;
        logic        active;
        logic [16:0] end_sum;
        logic [8:0]  pos_inc;
        logic [15:0] off_inc;

        clr     = s1_first_reg;
        active  = clr || !halted_reg;
        end_sum = 17'd0;
        pos_inc = 9'd0;
        off_inc = 16'd0;

        // a first-byte beat starts from cleared state
        offset_next   = clr ? 16'd0 : offset_reg;
        pos_next      = clr ? 8'd0  : pos_reg;
        len_next      = clr ? 8'd0  : len_reg;
        type_next     = clr ? 8'd0  : type_reg;
        mouse_next    = clr ? 1'b0  : mouse_reg;
        cfg_val_next  = clr ? 8'd0  : cfg_val_reg;
        if_num_next   = clr ? 8'd0  : if_num_reg;
        if_class_next = clr ? 8'd0  : if_class_reg;
        if_sub_next   = clr ? 8'd0  : if_sub_reg;
        if_proto_next = clr ? 8'd0  : if_proto_reg;
        ep_num_next   = clr ? 4'd0  : ep_num_reg;
        ep_in_next    = clr ? 1'b0  : ep_in_reg;
        ep_int_next   = clr ? 1'b0  : ep_int_reg;
        ep_mps_next   = clr ? 16'd0 : ep_mps_reg;
        rec_num_next  = clr ? 4'd0  : rec_num_reg;
        rec_mps_next  = clr ? 16'd0 : rec_mps_reg;
        rec_ivl_next  = clr ? 8'd0  : rec_ivl_reg;
        halted_next   = clr ? 1'b0  : halted_reg;

        result_now = 1'b0;
        status_now = ST_OK;

        if (active)
        begin
            if (set_len_reg == 16'd0)
            begin
                // empty set: report at once, byte not parsed
                result_now = 1'b1;
            end
            else
            begin
                if (pos_next == POS_LENGTH)
                begin
                    len_next = s1_byte_reg;
                    end_sum  = {1'b0, offset_next} + {9'd0, s1_byte_reg};
                    if (s1_byte_reg < MIN_DESC_LEN)
                    begin
                        result_now = 1'b1;
                        status_now = ST_LEN_SHORT;
                    end
                    else if (end_sum > {1'b0, set_len_reg})
                    begin
                        result_now = 1'b1;
                        status_now = ST_OVERRUN;
                    end
                end
                else if (pos_next == POS_TYPE)
                begin
                    type_next = s1_byte_reg;
                    if (s1_byte_reg == DT_CONFIGURATION && len_next < MIN_CONFIG_LEN)
                    begin
                        result_now = 1'b1;
                        status_now = ST_SHORT_CFG;
                    end
                    else if (s1_byte_reg == DT_INTERFACE && len_next < MIN_IFACE_LEN)
                    begin
                        result_now = 1'b1;
                        status_now = ST_SHORT_IFACE;
                    end
                    else if (s1_byte_reg == DT_ENDPOINT && len_next < MIN_EP_LEN)
                    begin
                        result_now = 1'b1;
                        status_now = ST_SHORT_EP;
                    end
                end
                else if (type_next == DT_CONFIGURATION)
                begin
                    if (pos_next == POS_CFG_VALUE)
                        cfg_val_next = s1_byte_reg;
                end
                else if (type_next == DT_INTERFACE)
                begin
                    if (pos_next == POS_IF_NUMBER)
                        if_num_next = s1_byte_reg;
                    else if (pos_next == POS_IF_CLASS)
                        if_class_next = s1_byte_reg;
                    else if (pos_next == POS_IF_SUB)
                        if_sub_next = s1_byte_reg;
                    else if (pos_next == POS_IF_PROTO)
                    begin
                        if_proto_next = s1_byte_reg;
                        if (if_class_next == HID_CLASS && if_sub_next == HID_BOOT_SUBCLASS
                            && s1_byte_reg == HID_MOUSE_PROTOCOL)
                            mouse_next = 1'b1;
                    end
                end
                else if (type_next == DT_ENDPOINT)
                begin
                    if (pos_next == POS_EP_ADDR)
                    begin
                        ep_num_next = s1_byte_reg[3:0] & EP_NUM_MASK[3:0];
                        ep_in_next  = (s1_byte_reg & EP_DIR_IN) != 8'd0;
                        ep_int_next = 1'b0;
                        ep_mps_next = 16'd0;
                    end
                    else if (pos_next == POS_EP_ATTR)
                    begin
                        if ((s1_byte_reg & EP_TYPE_MASK) == EP_TYPE_INTERRUPT)
                            ep_int_next = 1'b1;
                    end
                    else if (pos_next == POS_EP_MPS_LO)
                        ep_mps_next = ep_mps_next | {8'd0, s1_byte_reg};
                    else if (pos_next == POS_EP_MPS_HI)
                        ep_mps_next = ep_mps_next | {s1_byte_reg, 8'd0};
                    else if (pos_next == POS_EP_INTERVL)
                    begin
                        if (mouse_next && ep_in_next && ep_int_next)
                        begin
                            rec_num_next = ep_num_next;
                            rec_mps_next = ep_mps_next;
                            rec_ivl_next = s1_byte_reg;
                        end
                    end
                end

                if (!result_now)
                begin
                    pos_inc     = {1'b0, pos_next} + 9'd1;
                    pos_next    = (pos_inc >= {1'b0, len_next}) ? 8'd0 : pos_inc[7:0];
                    off_inc     = offset_next + 16'd1;
                    offset_next = off_inc;
                    if (off_inc >= set_len_reg)
                        result_now = 1'b1;
                end
            end

            if (result_now)
                halted_next = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the input register only holds when its byte would
    // produce a result and the output register is still blocked.
    // ---------------------------------------------------------------
    assign s1_go    = s1_valid_reg && (!result_now || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_len_reg      <= SET_LENGTH_RESET;
            s1_valid_reg     <= 1'b0;
            halted_reg       <= 1'b1;
            offset_reg       <= 16'd0;
            pos_reg          <= 8'd0;
            len_reg          <= 8'd0;
            type_reg         <= 8'd0;
            mouse_reg        <= 1'b0;
            cfg_val_reg      <= 8'd0;
            if_num_reg       <= 8'd0;
            if_class_reg     <= 8'd0;
            if_sub_reg       <= 8'd0;
            if_proto_reg     <= 8'd0;
            ep_num_reg       <= 4'd0;
            ep_in_reg        <= 1'b0;
            ep_int_reg       <= 1'b0;
            ep_mps_reg       <= 16'd0;
            rec_num_reg      <= 4'd0;
            rec_mps_reg      <= 16'd0;
            rec_ivl_reg      <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                set_len_reg <= cfg_wdata;

            s1_valid_reg <= s1_valid_next;

            if (s1_go)
            begin
                halted_reg   <= halted_next;
                offset_reg   <= offset_next;
                pos_reg      <= pos_next;
                len_reg      <= len_next;
                type_reg     <= type_next;
                mouse_reg    <= mouse_next;
                cfg_val_reg  <= cfg_val_next;
                if_num_reg   <= if_num_next;
                if_class_reg <= if_class_next;
                if_sub_reg   <= if_sub_next;
                if_proto_reg <= if_proto_next;
                ep_num_reg   <= ep_num_next;
                ep_in_reg    <= ep_in_next;
                ep_int_reg   <= ep_int_next;
                ep_mps_reg   <= ep_mps_next;
                rec_num_reg  <= rec_num_next;
                rec_mps_reg  <= rec_mps_next;
                rec_ivl_reg  <= rec_ivl_next;
            end

            if (s1_go && result_now)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // input and result payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_byte;
        end
        if (s1_go && result_now)
        begin
            out_status_reg <= status_now;
            out_cfg_reg    <= cfg_val_next;
            out_ifn_reg    <= if_num_next;
            out_ifc_reg    <= if_class_next;
            out_ifs_reg    <= if_sub_next;
            out_ifp_reg    <= if_proto_next;
            out_mouse_reg  <= mouse_next;
            out_epn_reg    <= rec_num_next;
            out_mps_reg    <= rec_mps_next;
            out_ivl_reg    <= rec_ivl_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign parse_status        = out_status_reg;
    assign config_value        = out_cfg_reg;
    assign iface_number        = out_ifn_reg;
    assign iface_class         = out_ifc_reg;
    assign iface_subclass      = out_ifs_reg;
    assign iface_protocol      = out_ifp_reg;
    assign mouse_found         = out_mouse_reg;
    assign mouse_endpoint      = out_epn_reg;
    assign endpoint_max_packet = out_mps_reg;
    assign endpoint_interval   = out_ivl_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // a byte seen while halted without a first-byte mark never reports
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && halted_reg && !s1_first_reg) |-> !result_now)
        else $error("result produced from a halted parser");

    // every reported result halts the parser
    a_result_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && result_now) |=> halted_reg)
        else $error("parser not halted after result");

    // input only holds back while a result waits downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // position inside a descriptor stays below its length
    a_pos_in_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 8'd0) |-> (pos_reg < len_reg))
        else $error("descriptor position past descriptor length");

endmodule

`default_nettype wire

### tb/tb_parse_check_pkg.sv
// tb_parse_check_pkg: descriptor-walk predictor and report scoreboard used by tb_top.
// Depends on usbcfg_pkg for descriptor codes, byte positions, minimum lengths and status_t.
package tb_parse_check_pkg;
    import usbcfg_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  cfg_value;
        logic [7:0]  if_number;
        logic [7:0]  if_class;
        logic [7:0]  if_subclass;
        logic [7:0]  if_protocol;
        logic        mouse;
        logic [3:0]  ep_number;
        logic [15:0] ep_max_packet;
        logic [7:0]  ep_interval;
    } parse_report_t;

    class parse_scoreboard;
        logic [15:0]   set_size;
        logic [15:0]   bytes_in_set;
        logic [7:0]    field_idx;
        logic [7:0]    cur_len;
        logic [7:0]    cur_type;
        bit            waiting;
        bit            mouse_seen;
        logic [7:0]    cap_cfg;
        logic [7:0]    cap_ifnum;
        logic [7:0]    cap_class;
        logic [7:0]    cap_sub;
        logic [7:0]    cap_proto;
        // 3:0 number, 4 IN, 5 interrupt, 23:8 max packet
        logic [23:0]   ep_build;
        logic [3:0]    ep_num;
        logic [15:0]   ep_mps;
        logic [7:0]    ep_ival;
        parse_report_t reports[$];
        int            errors;
        int            reports_seen;
        int            status_hits[6];
        int            mouse_reports;

        function new();
            set_size      = SET_LENGTH_RESET;
            errors        = 0;
            reports_seen  = 0;
            mouse_reports = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
            clear_set();
            waiting = 1'b1;
        endfunction

        function void clear_set();
            bytes_in_set = '0;
            field_idx    = '0;
            cur_len      = '0;
            cur_type     = '0;
            mouse_seen   = 1'b0;
            cap_cfg      = '0;
            cap_ifnum    = '0;
            cap_class    = '0;
            cap_sub      = '0;
            cap_proto    = '0;
            ep_build     = '0;
            ep_num       = '0;
            ep_mps       = '0;
            ep_ival      = '0;
        endfunction

        function void set_total(logic [15:0] v);
            set_size = v;
        endfunction

        function void close_set(status_t st);
            parse_report_t r;
            r.status        = st;
            r.cfg_value     = cap_cfg;
            r.if_number     = cap_ifnum;
            r.if_class      = cap_class;
            r.if_subclass   = cap_sub;
            r.if_protocol   = cap_proto;
            r.mouse         = mouse_seen;
            r.ep_number     = ep_num;
            r.ep_max_packet = ep_mps;
            r.ep_interval   = ep_ival;
            reports.push_back(r);
            waiting = 1'b1;
        endfunction

        // One accepted input beat.
        function void take_byte(logic [7:0] b, logic first);
            int unsigned idx;
            int unsigned reach;
            status_t     err;
            if (first) begin
                clear_set();
                waiting = 1'b0;
            end
            else if (waiting)
                return;
            // zero total: the byte closes the set unparsed
            if (set_size == 16'd0) begin
                close_set(ST_OK);
                return;
            end
            idx = field_idx;
            err = ST_OK;
            if (idx == POS_LENGTH) begin
                cur_len = b;
                reach   = int'(bytes_in_set) + int'(b);
                if (b < MIN_DESC_LEN)
                    err = ST_LEN_SHORT;
                else if (reach > int'(set_size))
                    err = ST_OVERRUN;
            end
            else if (idx == POS_TYPE) begin
                cur_type = b;
                if (b == DT_CONFIGURATION && cur_len < MIN_CONFIG_LEN)
                    err = ST_SHORT_CFG;
                else if (b == DT_INTERFACE && cur_len < MIN_IFACE_LEN)
                    err = ST_SHORT_IFACE;
                else if (b == DT_ENDPOINT && cur_len < MIN_EP_LEN)
                    err = ST_SHORT_EP;
            end
            else if (cur_type == DT_CONFIGURATION) begin
                if (idx == POS_CFG_VALUE)
                    cap_cfg = b;
            end
            else if (cur_type == DT_INTERFACE) begin
                if (idx == POS_IF_NUMBER)
                    cap_ifnum = b;
                else if (idx == POS_IF_CLASS)
                    cap_class = b;
                else if (idx == POS_IF_SUB)
                    cap_sub = b;
                else if (idx == POS_IF_PROTO) begin
                    cap_proto = b;
                    if (cap_class == HID_CLASS && cap_sub == HID_BOOT_SUBCLASS
                        && b == HID_MOUSE_PROTOCOL)
                        mouse_seen = 1'b1;
                end
            end
            else if (cur_type == DT_ENDPOINT) begin
                if (idx == POS_EP_ADDR) begin
                    ep_build = {16'd0, 4'd0, b[3:0] & EP_NUM_MASK[3:0]};
                    if ((b & EP_DIR_IN) != 8'd0)
                        ep_build[4] = 1'b1;
                end
                else if (idx == POS_EP_ATTR) begin
                    if ((b & EP_TYPE_MASK) == EP_TYPE_INTERRUPT)
                        ep_build[5] = 1'b1;
                end
                else if (idx == POS_EP_MPS_LO)
                    ep_build = ep_build | {8'd0, b, 8'd0};
                else if (idx == POS_EP_MPS_HI)
                    ep_build = ep_build | {b, 16'd0};
                else if (idx == POS_EP_INTERVL) begin
                    if (mouse_seen && ep_build[4] && ep_build[5]) begin
                        ep_num  = ep_build[3:0];
                        ep_mps  = ep_build[23:8];
                        ep_ival = b;
                    end
                end
            end
            if (err != ST_OK) begin
                close_set(err);
                return;
            end
            field_idx    = (idx + 1 >= int'(cur_len)) ? 8'd0 : 8'(idx + 1);
            bytes_in_set = bytes_in_set + 16'd1;
            if (bytes_in_set >= set_size)
                close_set(ST_OK);
        endfunction

        function void compare(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        // One accepted result beat against the oldest pending report.
        function void check_report(parse_report_t got);
            parse_report_t want;
            if (reports.size() == 0) begin
                $display("%0t: unexpected result beat, status %0h", $time, got.status);
                errors++;
                return;
            end
            want = reports.pop_front();
            reports_seen++;
            status_hits[want.status]++;
            if (want.ep_number != 4'd0)
                mouse_reports++;
            compare("parse_status", 16'(want.status), 16'(got.status));
            compare("config_value", 16'(want.cfg_value), 16'(got.cfg_value));
            compare("iface_number", 16'(want.if_number), 16'(got.if_number));
            compare("iface_class", 16'(want.if_class), 16'(got.if_class));
            compare("iface_subclass", 16'(want.if_subclass), 16'(got.if_subclass));
            compare("iface_protocol", 16'(want.if_protocol), 16'(got.if_protocol));
            compare("mouse_found", 16'(want.mouse), 16'(got.mouse));
            compare("mouse_endpoint", 16'(want.ep_number), 16'(got.ep_number));
            compare("endpoint_max_packet", want.ep_max_packet, got.ep_max_packet);
            compare("endpoint_interval", 16'(want.ep_interval), 16'(got.ep_interval));
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// tb_top: self-checking bench for usb_config_descriptor_parser (instance uut).
// Depends on usbcfg_pkg and tb_parse_check_pkg (predictor and report scoreboard).
module tb_top;
    import usbcfg_pkg::*;
    import tb_parse_check_pkg::*;

    // Percentage of cycles a side idles when idling is enabled.
    localparam int STALL_PCT      = 16;
    // Cycles with no beat on either channel before the run is declared hung.
    // Worst legal quiet stretch is a config write pause plus a few idle gaps.
    localparam int WATCHDOG_LIMIT = 2000;
    // Bytes of descriptor sets in the random phase.
    localparam int RANDOM_BYTES   = 1100;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_wdata  = 16'd0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = 8'd0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  parse_status;
    logic [7:0]  config_value;
    logic [7:0]  iface_number;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic        mouse_found;
    logic [3:0]  mouse_endpoint;
    logic [15:0] endpoint_max_packet;
    logic [7:0]  endpoint_interval;

    parse_scoreboard sb;
    // When set, neither side idles: a stretch of back-to-back beats.
    bit          calm = 1'b0;
    logic [15:0] cur_total = SET_LENGTH_RESET;
    logic [7:0]  set_bytes[$];
    int          bytes_sent = 0;
    int          sets_sent = 0;
    int          totals_written = 0;
    int          set_payload_bytes = 0;
    int          quiet_cycles = 0;

    usb_config_descriptor_parser uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .first_byte          (first_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .parse_status        (parse_status),
        .config_value        (config_value),
        .iface_number        (iface_number),
        .iface_class         (iface_class),
        .iface_subclass      (iface_subclass),
        .iface_protocol      (iface_protocol),
        .mouse_found         (mouse_found),
        .mouse_endpoint      (mouse_endpoint),
        .endpoint_max_packet (endpoint_max_packet),
        .endpoint_interval   (endpoint_interval)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side back-pressure, changed on the falling edge only.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end

    // Monitor: both channels sampled at the rising edge, before the design
    // updates its registers. The input beat is fed to the predictor first.
    always @(posedge clk)
    begin : monitor
        parse_report_t got;
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.take_byte(data_byte, first_byte);
            if (out_valid && !out_stall) begin
                got.status        = status_t'(parse_status);
                got.cfg_value     = config_value;
                got.if_number     = iface_number;
                got.if_class      = iface_class;
                got.if_subclass   = iface_subclass;
                got.if_protocol   = iface_protocol;
                got.mouse         = mouse_found;
                got.ep_number     = mouse_endpoint;
                got.ep_max_packet = endpoint_max_packet;
                got.ep_interval   = endpoint_interval;
                sb.check_report(got);
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d reports pending",
                     $time, quiet_cycles, sb.reports.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // Present one byte and hold it until the rising edge that accepts it.
    // Random idle cycles come before the byte; the payload never changes
    // while the beat is stalled.
    task automatic send_byte(input logic [7:0] b, input logic first);
        @(negedge clk);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the built set: first_byte marks only its opening byte.
    task automatic send_set();
        foreach (set_bytes[i])
            send_byte(set_bytes[i], i == 0);
        sets_sent++;
    endtask

    // The set length is only written with the block idle: every report in,
    // then a few cycles so that dropped bytes have left the pipeline.
    task automatic write_total(input logic [15:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.reports.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_total(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_total = v;
        totals_written++;
    endtask

    // Append a descriptor of len bytes with a random body; returns its
    // start index so callers can patch the fields they care about.
    function automatic int add_desc(input int len, input logic [7:0] typ);
        int base;
        base = set_bytes.size();
        set_bytes.push_back(8'(len));
        set_bytes.push_back(typ);
        for (int i = 2; i < len; i++)
            set_bytes.push_back(8'($urandom));
        return base;
    endfunction

    // Mostly the minimum length, sometimes a little longer, rarely huge.
    function automatic int pick_len(input int floor_len);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return floor_len;
        if (r < 98)
            return floor_len + $urandom_range(1, 4);
        return $urandom_range(floor_len, 255);
    endfunction

    function automatic void add_config();
        int base;
        base = add_desc(pick_len(MIN_CONFIG_LEN), DT_CONFIGURATION);
        set_bytes[base + POS_CFG_VALUE] = 8'($urandom);
    endfunction

    function automatic void add_iface();
        int base;
        int r;
        base = add_desc(pick_len(MIN_IFACE_LEN), DT_INTERFACE);
        r = $urandom_range(99);
        set_bytes[base + POS_IF_NUMBER] = 8'($urandom);
        if (r < 50) begin
            // boot mouse
            set_bytes[base + POS_IF_CLASS] = HID_CLASS;
            set_bytes[base + POS_IF_SUB]   = HID_BOOT_SUBCLASS;
            set_bytes[base + POS_IF_PROTO] = HID_MOUSE_PROTOCOL;
        end
        else if (r < 70) begin
            // HID, near misses on subclass / protocol
            set_bytes[base + POS_IF_CLASS] = HID_CLASS;
            set_bytes[base + POS_IF_SUB]   = 8'($urandom_range(0, 3));
            set_bytes[base + POS_IF_PROTO] = 8'($urandom_range(0, 3));
        end
    endfunction

    function automatic void add_endpoint();
        int base;
        logic [7:0] addr;
        logic [7:0] attr;
        base = add_desc(pick_len(MIN_EP_LEN), DT_ENDPOINT);
        addr = 8'($urandom);
        attr = 8'($urandom);
        addr[7] = ($urandom_range(99) < 65);
        if ($urandom_range(99) < 65)
            attr[1:0] = 2'b11;
        set_bytes[base + POS_EP_ADDR] = addr;
        set_bytes[base + POS_EP_ATTR] = attr;
    endfunction

    // A configuration descriptor, then one or two interfaces each with up
    // to two endpoints, with an occasional unknown descriptor in between.
    function automatic void build_set();
        logic [7:0] typ;
        set_bytes.delete();
        add_config();
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(99) < 25) begin
                typ = 8'($urandom);
                if (typ == DT_CONFIGURATION || typ == DT_INTERFACE || typ == DT_ENDPOINT)
                    typ = 8'h21;
                void'(add_desc(pick_len($urandom_range(2, 9)), typ));
            end
            add_iface();
            repeat ($urandom_range(0, 2))
                add_endpoint();
        end
    endfunction

    // Loose bytes with stray set marks; many small values so that lengths
    // and types below the minimums come up.
    task automatic noise_burst();
        logic [7:0] b;
        repeat ($urandom_range(5, 20)) begin
            b = ($urandom_range(1) == 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
            send_byte(b, $urandom_range(99) < 15);
        end
    endtask

    initial
    begin
        int          r;
        int          sum;
        logic [15:0] total;
        sb = new();
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // dropped: no set open yet
        send_byte(8'h09, 1'b0);
        // reset total of 9: one bare configuration descriptor
        set_bytes = '{8'h09, DT_CONFIGURATION, 8'h09, 8'h00, 8'h01, 8'hA5, 8'h00, 8'h80, 8'h32};
        send_set();
        // length below two, both values
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b1);
        // length past the end of the set
        send_byte(8'h0A, 1'b1);
        // too short for a configuration, interface, endpoint
        send_byte(8'h08, 1'b1);
        send_byte(DT_CONFIGURATION, 1'b0);
        send_byte(8'h08, 1'b1);
        send_byte(DT_INTERFACE, 1'b0);
        send_byte(8'h06, 1'b1);
        send_byte(DT_ENDPOINT, 1'b0);
        // zero total: the first byte alone closes the set, unparsed
        write_total(16'd0);
        send_byte(8'hFF, 1'b1);
        // total of one: a two-byte length overruns it
        write_total(16'd1);
        send_byte(8'h02, 1'b1);
        // largest total: a short unknown descriptor, then a bad length
        write_total(16'hFFFF);
        send_byte(8'h02, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);

        // ---- random ----
        while (set_payload_bytes < RANDOM_BYTES) begin
            calm = (set_payload_bytes > RANDOM_BYTES * 2 / 5)
                && (set_payload_bytes < RANDOM_BYTES * 11 / 20);
            if ($urandom_range(99) < 10)
                noise_burst();
            else begin
                build_set();
                sum = set_bytes.size();
                r = $urandom_range(99);
                if (r < 75)
                    total = 16'(sum);
                else if (r < 87) begin
                    // one byte corrupted
                    set_bytes[$urandom_range(0, sum - 1)] = 8'($urandom);
                    total = 16'(sum);
                end
                else if (r < 94)
                    // set ends early, possibly mid-descriptor
                    total = 16'($urandom_range(1, sum - 1));
                else
                    // set never completes; the next mark restarts it
                    total = 16'(sum + $urandom_range(1, 20));
                if (total != cur_total)
                    write_total(total);
                send_set();
                set_payload_bytes += sum;
                // trailing bytes after the set closed are dropped
                repeat ($urandom_range(0, 2))
                    send_byte(8'($urandom), 1'b0);
            end
        end
        calm = 1'b0;

        // ---- drain ----
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.reports.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("run covered %0d bytes, %0d built sets, %0d set length writes, %0d reports",
                 bytes_sent, sets_sent, totals_written, sb.reports_seen);
        $display("statuses ok/len/overrun/cfg/iface/ep %0d/%0d/%0d/%0d/%0d/%0d, %0d with mouse ep",
                 sb.status_hits[ST_OK], sb.status_hits[ST_LEN_SHORT],
                 sb.status_hits[ST_OVERRUN], sb.status_hits[ST_SHORT_CFG],
                 sb.status_hits[ST_SHORT_IFACE], sb.status_hits[ST_SHORT_EP],
                 sb.mouse_reports);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
